// ----- src/tcs_pkg.sv -----
// Package with shared types, constants and command structs for the two camera selector.
`default_nettype none
package tcs_pkg;

    localparam int MaxCameras = 16;
    localparam int CoordBits  = 24;
    localparam int IdxBits    = $clog2(MaxCameras);
    localparam int DiffBits   = CoordBits + 1;
    localparam int SqBits     = 2 * DiffBits;
    localparam int SumBits    = SqBits + 2;
    localparam int DistBits   = 25;
    localparam int DotBits    = SqBits + 2;
    localparam int CntBits    = 5;
    localparam int RootSteps  = (SumBits + 1) / 2;
    localparam int RootCntW   = $clog2(RootSteps + 1);
    localparam logic [CntBits-1:0] CountReset = CntBits'(16);
    localparam logic [CntBits-1:0] CountMin   = CntBits'(2);
    localparam logic [CntBits-1:0] CountLimit =
        (MaxCameras < 16) ? CntBits'(MaxCameras) : CntBits'(16);

    typedef struct packed {
        logic                        mode;
        logic [3:0]                  cam_index;
        logic signed [23:0]          pos_x;
        logic signed [23:0]          pos_y;
        logic signed [23:0]          pos_z;
    } t_in_item;

    typedef struct packed {
        logic [3:0]          first_id;
        logic [3:0]          second_id;
        logic [DistBits-1:0] first_dist;
        logic [DistBits-1:0] second_dist;
        logic                second_found;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               load_query;  // capture the virtual position
        logic               write_cam;   // write a table entry
        logic               rd_en;       // read table entry at rd_idx
        logic [IdxBits-1:0] rd_idx;
        logic               rd_first;    // read the first pick entry
        logic               diff_en;     // form differences for pass one
        logic               diff2_en;    // form differences for pass two
        logic               mul_en;      // multiply stage
        logic               sum_en;      // sum stage
        logic               root_start;
        logic               pass_two;    // current evaluation belongs to pass two
        logic               upd_first;
        logic               upd_second;
        logic               clr;
        logic               emit;
        logic               save_c1;
    } t_cmd;

    typedef struct packed {
        logic root_done;
    } t_status;

endpackage
`default_nettype wire

// ----- src/tcs_ctrl.sv -----
// Controller state machine that sequences the two table passes of a query.
`default_nettype none
module tcs_ctrl
    import tcs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               i_mode,
    input  wire logic [CntBits-1:0] i_count,
    input  wire logic [IdxBits-1:0] i_first_id,
    input  wire t_status            i_status,
    output logic                    busy,
    output t_cmd                    o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_DIFF  = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_SUM   = 10'b0000010000,
        S_ROOT  = 10'b0000100000,
        S_UPD   = 10'b0001000000,
        S_C1    = 10'b0010000000,
        S_C1W   = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } t_state;

    t_state             r_state, n_state;
    logic [IdxBits-1:0] r_idx, n_idx;
    logic               r_pass, n_pass;
    logic [CntBits-1:0] r_n, n_n;
    logic [CntBits-1:0] idx_ext;

    assign busy    = (r_state != S_IDLE);
    assign idx_ext = CntBits'(r_idx);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_pass  = r_pass;
        n_n     = r_n;
        o_cmd   = '0;
        o_cmd.rd_idx   = r_idx;
        o_cmd.pass_two = r_pass;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_mode == 1'b0) begin
                        o_cmd.write_cam = 1'b1;
                    end else begin
                        o_cmd.load_query = 1'b1;
                        o_cmd.clr        = 1'b1;
                        n_idx   = '0;
                        n_pass  = 1'b0;
                        if (i_count < CountMin)
                            n_n = CountMin;
                        else if (i_count > CountLimit)
                            n_n = CountLimit;
                        else
                            n_n = i_count;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_pass && (r_idx == i_first_id)) begin
                    if (idx_ext + 1'b1 >= r_n) begin
                        n_state = S_EMIT;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff_en  = ~r_pass;
                o_cmd.diff2_en = r_pass;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en     = 1'b1;
                o_cmd.root_start = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (i_status.root_done)
                    n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd_first  = ~r_pass;
                o_cmd.upd_second = r_pass;
                if (idx_ext + 1'b1 >= r_n) begin
                    n_idx = '0;
                    if (r_pass) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_C1;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_C1: begin
                o_cmd.rd_first = 1'b1;
                n_state = S_C1W;
            end
            S_C1W: begin
                o_cmd.save_c1 = 1'b1;
                n_pass  = 1'b1;
                n_state = S_RD;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_pass  <= 1'b0;
            r_n     <= CountReset;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pass  <= n_pass;
            r_n     <= n_n;
        end
    end

endmodule
`default_nettype wire

// ----- src/tcs_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module tcs_sqrt
    import tcs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [SumBits-1:0] i_value,
    output logic                    o_done,
    output logic [DistBits-1:0]     o_root
);

    logic [SumBits-1:0]  r_rem;
    logic [SumBits-1:0]  r_val;
    logic [RootSteps-1:0] r_root;
    logic [RootCntW-1:0] r_cnt;
    logic                r_busy;
    logic [SumBits+1:0]  trial;
    logic [SumBits+1:0]  cur;

    // Restoring digit step: bring down two bits, test root*4+1.
    assign cur   = {r_rem, r_val[SumBits-1 -: 2]};
    assign trial = (SumBits+2)'({r_root, 2'b01});
    assign o_done = r_busy && (r_cnt == '0);
    assign o_root = r_root[DistBits-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= RootCntW'(RootSteps);
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_val  <= i_value;
            r_root <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_val <= {r_val[SumBits-3:0], 2'b00};
            if (cur >= trial) begin
                r_rem  <= SumBits'(cur - trial);
                r_root <= {r_root[RootSteps-2:0], 1'b1};
            end else begin
                r_rem  <= SumBits'(cur);
                r_root <= {r_root[RootSteps-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/tcs_datapath.sv -----
// Datapath: camera table, difference, multiply and compare registers.
`default_nettype none
module tcs_datapath
    import tcs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_in_item           i_item,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    output logic [IdxBits-1:0]      o_first_id,
    output logic                    o_valid,
    output t_out_item               o_res
);

    logic signed [CoordBits-1:0] mem_x [MaxCameras];
    logic signed [CoordBits-1:0] mem_y [MaxCameras];
    logic signed [CoordBits-1:0] mem_z [MaxCameras];

    logic signed [CoordBits-1:0] r_vx, r_vy, r_vz;
    logic signed [CoordBits-1:0] r_cx, r_cy, r_cz;
    logic signed [CoordBits-1:0] r_fx, r_fy, r_fz;
    logic signed [DiffBits-1:0]  r_ax, r_ay, r_az;
    logic signed [DiffBits-1:0]  r_bx, r_by, r_bz;
    logic signed [DiffBits-1:0]  r_ex, r_ey, r_ez;
    logic signed [SqBits-1:0]    r_sx, r_sy, r_sz;
    logic signed [SqBits-1:0]    r_px, r_py, r_pz;
    logic signed [SqBits-1:0]    r_qx, r_qy, r_qz;
    logic [SumBits-1:0]          r_sum;
    logic                        r_ok;
    logic [IdxBits-1:0]          r_cur;
    logic [IdxBits-1:0]          r_first, r_second;
    logic [DistBits-1:0]         r_d1, r_d2;
    logic                        r_have1, r_have2;
    logic                        r_valid;
    t_out_item                   r_res;
    logic [DistBits-1:0]         root;
    logic                        root_done;
    logic signed [DotBits-1:0]   dot1, dot2;

    // Table write on a load transfer; indexes past the table are dropped.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_cam && (32'(i_item.cam_index) < MaxCameras)) begin
            mem_x[IdxBits'(i_item.cam_index)] <= CoordBits'(i_item.pos_x);
            mem_y[IdxBits'(i_item.cam_index)] <= CoordBits'(i_item.pos_y);
            mem_z[IdxBits'(i_item.cam_index)] <= CoordBits'(i_item.pos_z);
        end
    end

    // Registered table read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en || i_cmd.rd_first) begin
            r_cx <= mem_x[i_cmd.rd_first ? r_first : i_cmd.rd_idx];
            r_cy <= mem_y[i_cmd.rd_first ? r_first : i_cmd.rd_idx];
            r_cz <= mem_z[i_cmd.rd_first ? r_first : i_cmd.rd_idx];
            r_cur <= i_cmd.rd_idx;
        end
    end

    // Query position and first pick position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_vx <= CoordBits'(i_item.pos_x);
            r_vy <= CoordBits'(i_item.pos_y);
            r_vz <= CoordBits'(i_item.pos_z);
        end
        if (i_cmd.save_c1) begin
            r_fx <= r_cx;
            r_fy <= r_cy;
            r_fz <= r_cz;
        end
    end

    // Differences: distance vector a, axis b and first offset e.
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_en) begin
            r_ax <= DiffBits'(r_vx) - DiffBits'(r_cx);
            r_ay <= DiffBits'(r_vy) - DiffBits'(r_cy);
            r_az <= DiffBits'(r_vz) - DiffBits'(r_cz);
        end else if (i_cmd.diff2_en) begin
            r_ax <= DiffBits'(r_cx) - DiffBits'(r_vx);
            r_ay <= DiffBits'(r_cy) - DiffBits'(r_vy);
            r_az <= DiffBits'(r_cz) - DiffBits'(r_vz);
            r_bx <= DiffBits'(r_cx) - DiffBits'(r_fx);
            r_by <= DiffBits'(r_cy) - DiffBits'(r_fy);
            r_bz <= DiffBits'(r_cz) - DiffBits'(r_fz);
            r_ex <= DiffBits'(r_vx) - DiffBits'(r_fx);
            r_ey <= DiffBits'(r_vy) - DiffBits'(r_fy);
            r_ez <= DiffBits'(r_vz) - DiffBits'(r_fz);
        end
    end

    // Products, one per multiplier, registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_sx <= r_ax * r_ax;
            r_sy <= r_ay * r_ay;
            r_sz <= r_az * r_az;
            r_px <= r_ex * r_bx;
            r_py <= r_ey * r_by;
            r_pz <= r_ez * r_bz;
            r_qx <= r_ax * r_bx;
            r_qy <= r_ay * r_by;
            r_qz <= r_az * r_bz;
        end
    end

    assign dot1 = DotBits'(r_px) + DotBits'(r_py) + DotBits'(r_pz);
    assign dot2 = DotBits'(r_qx) + DotBits'(r_qy) + DotBits'(r_qz);

    // Sums of squares and the two sign tests.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_en) begin
            r_sum <= SumBits'(r_sx) + SumBits'(r_sy) + SumBits'(r_sz);
            r_ok  <= !dot1[DotBits-1] && !dot2[DotBits-1];
        end
    end

    tcs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_start),
        .i_value (i_cmd.sum_en ? SumBits'(r_sx) + SumBits'(r_sy) + SumBits'(r_sz)
                               : r_sum),
        .o_done  (root_done),
        .o_root  (root)
    );

    assign o_status.root_done = root_done;

    // Running best picks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have1 <= 1'b0;
            r_have2 <= 1'b0;
            r_first <= '0;
        end else if (i_cmd.clr) begin
            r_have1 <= 1'b0;
            r_have2 <= 1'b0;
        end else if (i_cmd.upd_first) begin
            if (!r_have1 || (root <= r_d1)) begin
                r_d1    <= root;
                r_first <= r_cur;
                r_have1 <= 1'b1;
            end
        end else if (i_cmd.upd_second) begin
            if (r_ok && (!r_have2 || (root < r_d2))) begin
                r_d2     <= root;
                r_second <= r_cur;
                r_have2  <= 1'b1;
            end
        end
    end

    assign o_first_id = r_first;

    // Result register, shown for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_res.first_id     <= 4'(r_first);
            r_res.first_dist   <= r_d1;
            r_res.second_found <= r_have2;
            r_res.second_id    <= r_have2 ? 4'(r_second) : 4'(r_first);
            r_res.second_dist  <= r_have2 ? r_d2 : r_d1;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

// ----- src/two_camera_selector.sv -----
// Top level of the two camera selector: configuration register, controller and datapath.
//
//  Channel   Signals                         Transfer when
//  command   start, busy, i_item             start high and busy low
//  result    o_done, o_result                o_done high (one cycle)
//  config    i_cfg_we, i_cfg_data            i_cfg_we high
//
// The iterative square root produces one root bit per cycle and is shared by both table passes.
// busy stays high for the whole query.
// Reset is synchronous and active low; the table holds no reset value.
// Results cannot be stalled: o_done marks a single valid cycle.
`default_nettype none
module two_camera_selector
    import tcs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_in_item           i_item,
    output logic                    o_done,
    output t_out_item               o_result,
    input  wire logic               i_cfg_we,
    input  wire logic [CntBits-1:0] i_cfg_data
);

    logic [CntBits-1:0] r_count;
    t_cmd               cmd;
    t_status            status;
    logic [IdxBits-1:0] first_id;

    // Camera count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CountReset;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    tcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_mode     (i_item.mode),
        .i_count    (r_count),
        .i_first_id (first_id),
        .i_status   (status),
        .busy       (busy),
        .o_cmd      (cmd)
    );

    tcs_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_first_id (first_id),
        .o_valid    (o_done),
        .o_res      (o_result)
    );

endmodule
`default_nettype wire
